FILE: hdl/arpc_pkg.sv
// Shared constants and types for the ARP cache responder.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

	localparam logic [15:0] HW_ETHERNET    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

	localparam logic [1:0] TX_OP_NONE    = 2'd0;
	localparam logic [1:0] TX_OP_REQUEST = 2'd1;
	localparam logic [1:0] TX_OP_REPLY   = 2'd2;

	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_REPLY   = 2'd1;
	localparam logic [1:0] KIND_REQUEST = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HW     = 3'd1;
	localparam logic [2:0] ST_BAD_PROTO  = 3'd2;
	localparam logic [2:0] ST_NOT_FOR_US = 3'd3;
	localparam logic [2:0] ST_BAD_OPCODE = 3'd4;
	localparam logic [2:0] ST_MISS       = 3'd5;

	localparam logic CFG_OWN_IP  = 1'b0;
	localparam logic CFG_OWN_MAC = 1'b1;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

	// Outcome of one pass over the cache
	typedef struct packed {
		logic        done;
		logic        match;
		logic        free;
		logic [47:0] match_mac;
	} scan_status_t;

endpackage
`default_nettype wire

FILE: hdl/arpc_cache.sv
// Cache memory with valid bits and a sequential scan for match and free entry.
`timescale 1ns / 1ps
`default_nettype none
module arpc_cache import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 16,
	parameter int IDX_W = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               scan_start,
	input  wire logic [31:0]        key,
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_idx,
	input  wire logic [31:0]        wr_ip,
	input  wire logic [47:0]        wr_mac,
	output scan_status_t            status,
	output logic      [IDX_W-1:0]   match_idx,
	output logic      [IDX_W-1:0]   free_idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	logic [79:0]              mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	logic             scan_q;
	logic [IDX_W-1:0] addr_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [79:0]      rd_data_s1;
	logic             done_q;
	logic             match_q;
	logic             free_q;
	logic [31:0]      key_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [47:0]      match_mac_q;

	logic entry_ok;
	logic entry_hit;

	assign entry_ok  = valid_q[rd_idx_s1];
	assign entry_hit = entry_ok && (rd_data_s1[79:48] == key_q);

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_ip, wr_mac};
		end
		rd_data_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			scan_q     <= 1'b0;
			addr_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			done_q     <= 1'b0;
			match_q    <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			rd_vld_s1  <= scan_q;
			rd_last_s1 <= scan_q && (addr_q == LAST_IDX);
			done_q     <= rd_vld_s1 && rd_last_s1;
			if (scan_start) begin
				scan_q  <= 1'b1;
				addr_q  <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (scan_q) begin
					if (addr_q == LAST_IDX) begin
						scan_q <= 1'b0;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				if (rd_vld_s1) begin
					// keep the lowest-numbered candidate of each kind
					if (entry_hit && !match_q) begin
						match_q <= 1'b1;
					end
					if (!entry_ok && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (scan_start) begin
			key_q <= key;
		end
		if (rd_vld_s1 && entry_hit && !match_q) begin
			match_idx_q <= rd_idx_s1;
			match_mac_q <= rd_data_s1[47:0];
		end
		if (rd_vld_s1 && !entry_ok && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	assign status.done      = done_q;
	assign status.match     = match_q;
	assign status.free      = free_q;
	assign status.match_mac = match_mac_q;
	assign match_idx        = match_idx_q;
	assign free_idx         = free_idx_q;

endmodule
`default_nettype wire

FILE: hdl/arp_cache_responder.sv
// ARP cache and responder for IPv4 over Ethernet: control and result logic.
// A lookup or an accepted packet is scanned against the cache and the scan reads
//   one entry per cycle; done and the result word are registered once the scan reports.
// A packet with a bad hardware or protocol type reports on the next cycle.
// No new command is accepted while a scan runs; busy is high meanwhile.
// Reset clears the valid bits and own_ip/own_mac; no clearing pass is needed.
// Results are one-cycle strobes on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_responder import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [47:0] cfg_data,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [15:0] hw_type,
	input  wire logic [15:0] proto_type,
	input  wire logic [15:0] arp_opcode,
	input  wire logic [31:0] sender_ip,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] target_ip,
	input  wire logic [31:0] query_ip,
	// result channel
	output logic             done,
	output logic [1:0]       transmit_kind,
	output logic [2:0]       status,
	output logic             table_full,
	output logic [47:0]      frame_dest_mac,
	output logic [1:0]       tx_opcode,
	output logic [47:0]      tx_target_mac,
	output logic [31:0]      tx_target_ip,
	output logic [47:0]      found_mac,
	output logic             hit
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic state_q;

	// configuration
	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;

	// captured command word
	logic        op_q;
	logic [15:0] opc_q;
	logic [31:0] sip_q;
	logic [47:0] smac_q;
	logic [31:0] tip_q;
	logic [31:0] qip_q;

	logic accept;
	logic reject_hw;
	logic reject_proto;

	scan_status_t     scan;
	logic [IDX_W-1:0] match_idx;
	logic [IDX_W-1:0] free_idx;
	logic             scan_start;
	logic             finish;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;

	// next result word, built when the scan reports
	logic [1:0]  kind_d;
	logic [2:0]  status_d;
	logic        full_d;
	logic [47:0] dest_d;
	logic [1:0]  txop_d;
	logic [47:0] tmac_d;
	logic [31:0] tip_d;
	logic [47:0] found_d;
	logic        hit_d;

	assign cfg_ready    = 1'b1;
	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign reject_hw    = (hw_type != HW_ETHERNET);
	assign reject_proto = (proto_type != PROTO_IPV4);
	// packets with bad header types never touch the cache
	assign scan_start   = accept && (operation || (!reject_hw && !reject_proto));
	assign finish       = (state_q == S_SCAN) && scan.done;

	// learn the sender: update a matching entry, else take the first free one
	assign wr_en  = finish && !op_q && (scan.match || scan.free);
	assign wr_idx = scan.match ? match_idx : free_idx;

	always_comb begin
		kind_d   = KIND_NONE;
		status_d = ST_OK;
		full_d   = 1'b0;
		dest_d   = '0;
		txop_d   = TX_OP_NONE;
		tmac_d   = '0;
		tip_d    = '0;
		found_d  = '0;
		hit_d    = 1'b0;
		if (op_q) begin
			if (scan.match) begin
				hit_d   = 1'b1;
				found_d = scan.match_mac;
			end else begin
				// miss: one broadcast request, no retries
				status_d = ST_MISS;
				kind_d   = KIND_REQUEST;
				dest_d   = BCAST_MAC;
				txop_d   = TX_OP_REQUEST;
				tmac_d   = BCAST_MAC;
				tip_d    = qip_q;
			end
		end else begin
			full_d = !scan.match && !scan.free;
			if (tip_q != own_ip_q) begin
				status_d = ST_NOT_FOR_US;
			end else if (opc_q == ARP_OP_REQUEST) begin
				kind_d = KIND_REPLY;
				dest_d = smac_q;
				txop_d = TX_OP_REPLY;
				tmac_d = smac_q;
				tip_d  = sip_q;
			end else if (opc_q != ARP_OP_REPLY) begin
				status_d = ST_BAD_OPCODE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done      <= 1'b0;
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OWN_IP:  own_ip_q  <= cfg_data[31:0];
					CFG_OWN_MAC: own_mac_q <= cfg_data;
					default:     ;
				endcase
			end
			// strobe a result for early rejects and for finished scans
			done <= (accept && !scan_start) || finish;
			case (state_q)
				S_IDLE: begin
					if (scan_start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan.done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: hold the command word and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			opc_q  <= arp_opcode;
			sip_q  <= sender_ip;
			smac_q <= sender_mac;
			tip_q  <= target_ip;
			qip_q  <= query_ip;
		end
		if (accept && !scan_start) begin
			transmit_kind  <= KIND_NONE;
			status         <= reject_hw ? ST_BAD_HW : ST_BAD_PROTO;
			table_full     <= 1'b0;
			frame_dest_mac <= '0;
			tx_opcode      <= TX_OP_NONE;
			tx_target_mac  <= '0;
			tx_target_ip   <= '0;
			found_mac      <= '0;
			hit            <= 1'b0;
		end else if (finish) begin
			transmit_kind  <= kind_d;
			status         <= status_d;
			table_full     <= full_d;
			frame_dest_mac <= dest_d;
			tx_opcode      <= txop_d;
			tx_target_mac  <= tmac_d;
			tx_target_ip   <= tip_d;
			found_mac      <= found_d;
			hit            <= hit_d;
		end
	end

	arpc_cache #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.IDX_W(IDX_W)
	) u_cache (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_start(scan_start),
		.key       (operation ? query_ip : sender_ip),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_ip     (sip_q),
		.wr_mac    (smac_q),
		.status    (scan),
		.match_idx (match_idx),
		.free_idx  (free_idx)
	);

	// own_mac is kept for the transmit path; the result word carries no sender MAC
	logic own_mac_unused;
	assign own_mac_unused = ^own_mac_q;

endmodule
`default_nettype wire
